### hw/rtl/rnnt_pkg.sv
`default_nettype none
package rnnt_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_CHOSEN  = 2'd1;
    localparam logic [1:0] STAT_CLOSED  = 2'd2;
    localparam logic [1:0] STAT_NO_TOUR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd2;

    localparam logic [16:0] THRESHOLD_RESET = 17'd52429;
    localparam logic [31:0] SEED_RESET      = 32'd1;
    localparam logic [10:0] COUNT_RESET     = 11'd1024;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  city_index;
        logic [15:0] city_x;
        logic [15:0] city_y;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  dest_city;
        logic [16:0] step_distance;
        logic [31:0] total_distance;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

### hw/rtl/rnnt_isqrt.sv
`default_nettype none
module rnnt_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] operand,
    output logic        done,
    output logic [16:0] root
);
    import rnnt_pkg::*;

    logic [34:0] rem_reg;
    logic [34:0] res_reg;
    logic [34:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] trial;

    assign trial = res_reg + bit_reg;

    // one result bit per cycle, bit walks from 2^34 down by a factor of four
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            res_reg  <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
            begin
                rem_reg  <= 35'(operand);
                res_reg  <= '0;
                bit_reg  <= 35'h4_0000_0000;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[16:0];

endmodule
`default_nettype wire

### hw/rtl/randomized_nearest_neighbor_tour.sv
`default_nettype none
// Greedy tour builder with a randomized choice between the closest and second closest
// unvisited city. A load, an unused command or a step with no tour active completes in the
// cycle it is accepted. A start clears the visited flags one city a cycle, marking city 0
// as visited. A step reads the current city, scans the cities in use one per cycle through
// a three-stage distance pipeline, then runs a bit-serial square root; a step that closes
// the tour first scans again to re-read city 0. One item is worked on at a time and the
// next is accepted once the result register is free or being taken.
module randomized_nearest_neighbor_tour #(
    parameter int MAX_CITIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  rnnt_pkg::item_t                item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output rnnt_pkg::result_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rnnt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import rnnt_pkg::*;

    localparam int AW = $clog2(MAX_CITIES);
    localparam int CW = $clog2(MAX_CITIES + 1);
    localparam int LW = (CW > 11) ? CW : 11;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_CLEAR    = 7'b0000010,
        ST_READ_CUR = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_PICK     = 7'b0010000,
        ST_SQRT     = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;

    logic [16:0] thresh_reg;
    logic [31:0] seed_reg;
    logic [10:0] count_reg;

    logic [AW-1:0] cur_reg;
    logic [31:0]   run_len_reg;
    logic          active_reg;
    logic [31:0]   prng_reg;

    logic [31:0] xy_mem [MAX_CITIES];
    logic        vis_mem [MAX_CITIES];
    logic [31:0] xy_rd_reg;
    logic        vis_rd_reg;

    logic          xy_we;
    logic [AW-1:0] xy_wa;
    logic          vis_we;
    logic [AW-1:0] vis_wa;
    logic          vis_wd;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] clr_cnt_reg;
    logic [CW-1:0] scan_cnt_reg;
    logic          close_reg;
    logic          cur_load_reg;
    logic [15:0]   cur_x_reg;
    logic [15:0]   cur_y_reg;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          s2_valid_reg;
    logic [AW-1:0] s2_idx_reg;
    logic [31:0]   sqx_reg;
    logic [31:0]   sqy_reg;

    logic          have1_reg;
    logic          have2_reg;
    logic [32:0]   best1_reg;
    logic [32:0]   best2_reg;
    logic [AW-1:0] c1_reg;
    logic [AW-1:0] c2_reg;

    logic [1:0]    status_reg;
    logic [16:0]   step_reg;
    logic          result_valid_reg;
    result_t       result_reg;
    result_t       result_next;
    logic          res_load;

    logic          out_free;
    logic          accept;
    logic [LW-1:0] count_ext;
    logic [CW-1:0] city_lim;
    logic [CW-1:0] scan_lim;
    logic          issue;
    logic [15:0]   adx;
    logic [15:0]   ady;
    logic [32:0]   cand_dist;
    logic [31:0]   prng_new;
    logic          take2;
    logic [AW-1:0] pick;
    logic [32:0]   pick_dist;
    logic          sq_start;
    logic          sq_done;
    logic [16:0]   sq_root;
    logic [32:0]   sat_sum;

    rnnt_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (pick_dist),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || result_ready;
    assign item_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign count_ext = LW'(count_reg);
    assign city_lim  = (count_ext > LW'(MAX_CITIES)) ? CW'(MAX_CITIES) : CW'(count_ext);
    assign scan_lim  = close_reg ? CW'(1) : city_lim;
    assign issue     = (state_reg == ST_SCAN) && (scan_cnt_reg < scan_lim);

    assign adx  = (xy_rd_reg[31:16] >= cur_x_reg) ? xy_rd_reg[31:16] - cur_x_reg
                                                  : cur_x_reg - xy_rd_reg[31:16];
    assign ady  = (xy_rd_reg[15:0] >= cur_y_reg) ? xy_rd_reg[15:0] - cur_y_reg
                                                 : cur_y_reg - xy_rd_reg[15:0];
    assign cand_dist = 33'(sqx_reg) + 33'(sqy_reg);

    // xorshift32
    always_comb
    begin
        prng_new = prng_reg ^ (prng_reg << 13);
        prng_new = prng_new ^ (prng_new >> 17);
        prng_new = prng_new ^ (prng_new << 5);
    end

    assign take2     = !close_reg && have2_reg && ({1'b0, prng_new[31:16]} >= thresh_reg);
    assign pick      = take2 ? c2_reg : c1_reg;
    assign pick_dist = take2 ? best2_reg : best1_reg;
    assign sq_start  = (state_reg == ST_PICK);
    assign sat_sum   = 33'(run_len_reg) + 33'(sq_root);

    // immediate transactions in idle, finished ones from done
    assign res_load = ((state_reg == ST_IDLE) && accept && (item.command != CMD_START)
                       && !((item.command == CMD_STEP) && active_reg))
                      || ((state_reg == ST_DONE) && out_free);

    always_comb
    begin
        result_next = '0;
        if (state_reg == ST_DONE)
        begin
            result_next.status = status_reg;
            if (status_reg != STAT_OK)
            begin
                result_next.dest_city      = (status_reg == STAT_CHOSEN) ? 10'(cur_reg) : '0;
                result_next.step_distance  = step_reg;
                result_next.total_distance = run_len_reg;
                result_next.last           = (status_reg == STAT_CLOSED);
            end
        end
        else
        begin
            result_next.status = (item.command == CMD_STEP) ? STAT_NO_TOUR : STAT_OK;
        end
    end

    always_comb
    begin
        xy_we   = accept && (item.command == CMD_LOAD)
                  && (LW'(item.city_index) < LW'(MAX_CITIES));
        xy_wa   = AW'(item.city_index);
        vis_we  = 1'b0;
        vis_wa  = clr_cnt_reg[AW-1:0];
        vis_wd  = 1'b0;
        rd_addr = cur_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vis_we = 1'b1;
                vis_wd = (clr_cnt_reg == '0);
            end
            ST_SCAN:
            begin
                rd_addr = close_reg ? '0 : scan_cnt_reg[AW-1:0];
            end
            ST_PICK:
            begin
                vis_we = !close_reg;
                vis_wa = pick;
                vis_wd = 1'b1;
            end
            default:
            begin
                rd_addr = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (xy_we)
        begin
            xy_mem[xy_wa] <= {item.city_x, item.city_y};
        end
        xy_rd_reg <= xy_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_wa] <= vis_wd;
        end
        vis_rd_reg <= vis_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESHOLD_RESET;
            seed_reg   <= SEED_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thresh_reg <= cfg_data[16:0];
                CFG_SEED:      seed_reg   <= cfg_data;
                CFG_COUNT:     count_reg  <= cfg_data[10:0];
                default:       thresh_reg <= thresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else if (res_load)
        begin
            result_valid_reg <= 1'b1;
            result_reg       <= result_next;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cur_reg          <= '0;
            run_len_reg      <= '0;
            active_reg       <= 1'b0;
            prng_reg         <= 32'd1;
            clr_cnt_reg      <= '0;
            scan_cnt_reg     <= '0;
            close_reg        <= 1'b0;
            cur_load_reg     <= 1'b0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s1_idx_reg       <= '0;
            s2_valid_reg     <= 1'b0;
            s2_idx_reg       <= '0;
            sqx_reg          <= '0;
            sqy_reg          <= '0;
            have1_reg        <= 1'b0;
            have2_reg        <= 1'b0;
            best1_reg        <= '0;
            best2_reg        <= '0;
            c1_reg           <= '0;
            c2_reg           <= '0;
            status_reg       <= STAT_OK;
            step_reg         <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.command == CMD_START)
                        begin
                            active_reg  <= 1'b1;
                            cur_reg     <= '0;
                            run_len_reg <= '0;
                            prng_reg    <= (seed_reg != '0) ? seed_reg : 32'd1;
                            clr_cnt_reg <= '0;
                            status_reg  <= STAT_OK;
                            state_reg   <= ST_CLEAR;
                        end
                        else if (item.command == CMD_STEP && active_reg)
                        begin
                            state_reg <= ST_READ_CUR;
                        end
                    end
                end
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CW'(MAX_CITIES - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_READ_CUR:
                begin
                    cur_load_reg <= 1'b1;
                    scan_cnt_reg <= '0;
                    close_reg    <= 1'b0;
                    have1_reg    <= 1'b0;
                    have2_reg    <= 1'b0;
                    s1_valid_reg <= 1'b0;
                    s2_valid_reg <= 1'b0;
                    state_reg    <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (cur_load_reg)
                    begin
                        cur_x_reg    <= xy_rd_reg[31:16];
                        cur_y_reg    <= xy_rd_reg[15:0];
                        cur_load_reg <= 1'b0;
                    end
                    if (issue)
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                    s1_valid_reg <= issue;
                    s1_idx_reg   <= rd_addr;
                    // closing re-reads city 0 and takes it regardless of its flag
                    s2_valid_reg <= s1_valid_reg && (close_reg || !vis_rd_reg);
                    s2_idx_reg   <= s1_idx_reg;
                    sqx_reg      <= adx * adx;
                    sqy_reg      <= ady * ady;
                    if (s2_valid_reg)
                    begin
                        if (!have1_reg || cand_dist < best1_reg)
                        begin
                            best2_reg <= best1_reg;
                            c2_reg    <= c1_reg;
                            have2_reg <= have1_reg;
                            best1_reg <= cand_dist;
                            c1_reg    <= s2_idx_reg;
                            have1_reg <= 1'b1;
                        end
                        else if (!have2_reg || cand_dist < best2_reg)
                        begin
                            best2_reg <= cand_dist;
                            c2_reg    <= s2_idx_reg;
                            have2_reg <= 1'b1;
                        end
                    end
                    if (!issue && !s1_valid_reg && !s2_valid_reg)
                    begin
                        if (have1_reg)
                        begin
                            state_reg <= ST_PICK;
                        end
                        else
                        begin
                            close_reg    <= 1'b1;
                            scan_cnt_reg <= '0;
                        end
                    end
                end
                ST_PICK:
                begin
                    if (close_reg)
                    begin
                        active_reg <= 1'b0;
                        status_reg <= STAT_CLOSED;
                    end
                    else
                    begin
                        prng_reg   <= prng_new;
                        status_reg <= STAT_CHOSEN;
                    end
                    cur_reg   <= pick;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (sq_done)
                    begin
                        step_reg    <= sq_root;
                        run_len_reg <= sat_sum[32] ? '1 : sat_sum[31:0];
                        state_reg   <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> state_reg == ST_IDLE)
        else $error("item taken outside idle");

    a_last_closed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last == (result.status == STAT_CLOSED)))
        else $error("last flag and closed status disagree");

    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> $past(s1_valid_reg))
        else $error("distance stage fired without a read");

endmodule
`default_nettype wire

### dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rnnt_pkg::*;

    localparam int NCITY = 1024;
    // cities given coordinates before any tour; city counts stay within this
    localparam int NLOAD = 40;
    // start clears the flags one city a cycle; a full-size step is about the same
    localparam int SETTLE_CYCLES = 1300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    randomized_nearest_neighbor_tour dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [15:0] x_coord [NCITY];
    logic [15:0] y_coord [NCITY];
    logic [NCITY-1:0] seen;
    int unsigned cur_city;
    logic [31:0] tour_len;
    bit          touring;
    logic [31:0] lfsr;
    logic [16:0] pick_threshold = THRESHOLD_RESET;
    logic [31:0] tour_seed = SEED_RESET;
    logic [10:0] cities_used = COUNT_RESET;

    item_t   pending_items [$];
    result_t expected_results [$];
    int      mismatch_count = 0;
    int      idle_mode = 0;
    logic    holding = 1'b0;
    bit      hold_go = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned span_sq(int unsigned a, int unsigned b);
        longint dx;
        longint dy;
        dx = longint'(x_coord[a]) - longint'(x_coord[b]);
        dy = longint'(y_coord[a]) - longint'(y_coord[b]);
        return longint'(dx * dx + dy * dy);
    endfunction

    function automatic logic [31:0] floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 17; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic result_t tour_predict(item_t it);
        result_t r;
        int unsigned n;
        int unsigned c1;
        int unsigned c2;
        int unsigned pick;
        longint unsigned d;
        longint unsigned b1;
        longint unsigned b2;
        longint unsigned pd;
        bit h1;
        bit h2;
        logic [31:0] s;
        logic [31:0] step;
        r = '0;
        case (it.command)
            CMD_LOAD:
            begin
                x_coord[it.city_index] = it.city_x;
                y_coord[it.city_index] = it.city_y;
            end
            CMD_START:
            begin
                seen = '0;
                seen[0] = 1'b1;
                cur_city = 0;
                tour_len = '0;
                touring = 1;
                lfsr = (tour_seed == 0) ? 32'd1 : tour_seed;
            end
            CMD_STEP:
            begin
                if (!touring) begin
                    r.status = STAT_NO_TOUR;
                end else begin
                    n = (cities_used > NCITY) ? NCITY : cities_used;
                    h1 = 0; h2 = 0; c1 = 0; c2 = 0; b1 = 0; b2 = 0;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (!seen[i]) begin
                            d = span_sq(cur_city, i);
                            if (!h1 || d < b1) begin
                                b2 = b1; c2 = c1; h2 = h1;
                                b1 = d; c1 = i; h1 = 1;
                            end else if (!h2 || d < b2) begin
                                b2 = d; c2 = i; h2 = 1;
                            end
                        end
                    end
                    if (h1) begin
                        s = lfsr;
                        s = s ^ (s << 13);
                        s = s ^ (s >> 17);
                        s = s ^ (s << 5);
                        lfsr = s;
                        pick = c1;
                        pd = b1;
                        if (h2 && {1'b0, s[31:16]} >= pick_threshold) begin
                            pick = c2;
                            pd = b2;
                        end
                        step = floor_root(pd);
                        tour_len = add_clamped(tour_len, step);
                        seen[pick] = 1'b1;
                        cur_city = pick;
                        r.status = STAT_CHOSEN;
                        r.dest_city = pick[9:0];
                    end else begin
                        step = floor_root(span_sq(cur_city, 0));
                        tour_len = add_clamped(tour_len, step);
                        cur_city = 0;
                        touring = 0;
                        r.status = STAT_CLOSED;
                        r.last = 1'b1;
                    end
                    r.step_distance = step[16:0];
                    r.total_distance = tour_len;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (item_valid && item_ready)
                expected_results.push_back(tour_predict(item));
            if (!item_valid || item_ready) begin
                if (pending_items.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 51) ||
                      (idle_mode == 3 && $urandom_range(99) < 34))) begin
                    item <= pending_items.pop_front();
                    item_valid <= 1'b1;
                end else begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transaction", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                    if (result.dest_city !== want.dest_city)
                        report_mismatch("dest_city", result.dest_city, want.dest_city);
                    if (result.step_distance !== want.step_distance)
                        report_mismatch("step_distance", result.step_distance,
                                        want.step_distance);
                    if (result.total_distance !== want.total_distance)
                        report_mismatch("total_distance", result.total_distance,
                                        want.total_distance);
                    if (result.last !== want.last)
                        report_mismatch("last", result.last, want.last);
                end
            end
            if (holding)
                result_ready <= 1'b0;
            else if (idle_mode == 2)
                result_ready <= ($urandom_range(99) >= 51);
            else if (idle_mode == 3)
                result_ready <= ($urandom_range(99) >= 34);
            else
                result_ready <= 1'b1;
        end
    end

    // long receiver hold-off
    initial begin
        wait (hold_go);
        @(posedge clk);
        holding <= 1'b1;
        repeat (2500) @(posedge clk);
        holding <= 1'b0;
    end

    task automatic push_load(int unsigned idx, int unsigned x, int unsigned y);
        item_t it;
        it.command = CMD_LOAD;
        it.city_index = idx[9:0];
        it.city_x = x[15:0];
        it.city_y = y[15:0];
        pending_items.push_back(it);
    endtask

    task automatic push_cmd(logic [1:0] cmd);
        item_t it;
        it.command = cmd;
        it.city_index = 10'($urandom());
        it.city_x = 16'($urandom());
        it.city_y = 16'($urandom());
        pending_items.push_back(it);
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESHOLD: pick_threshold = val[16:0];
            CFG_SEED:      tour_seed = val;
            CFG_COUNT:     cities_used = val[10:0];
            default: ;
        endcase
    endtask

    // a tour start and nsteps steps with a few loads mixed in
    task automatic push_tour(int unsigned nsteps);
        push_cmd(CMD_START);
        for (int unsigned k = 0; k < nsteps; k++) begin
            if ($urandom_range(9) == 0)
                push_load($urandom_range(NCITY - 1), $urandom(), $urandom());
            push_cmd(CMD_STEP);
        end
    endtask

    task automatic run_phase(int unsigned n_items, int unsigned eff);
        int unsigned base;
        base = pending_items.size();
        while (pending_items.size() - base < n_items) begin
            if ($urandom_range(99) < 75) begin
                if (eff <= 16)
                    push_tour(($urandom_range(4) == 0) ? $urandom_range(eff) : eff + 1);
                else
                    push_tour($urandom_range(1, 3));
            end else begin
                case ($urandom_range(3))
                    0: push_load($urandom_range(NCITY - 1), $urandom(), $urandom());
                    1: push_cmd(CMD_STEP);
                    2: push_cmd(CMD_NOP);
                    default: push_cmd(CMD_START);
                endcase
            end
        end
    endtask

    initial begin
        logic [31:0] thr_vals [9];
        logic [31:0] seed_vals [9];
        logic [31:0] cnt_vals [9];
        int unsigned eff;
        thr_vals  = '{52429, 0, 65536, 131071, 30000, 65535, 1, 100000, 52429};
        seed_vals = '{1, 0, 32'hFFFF_FFFF, 32'h1234_5678, 7, 32'h8000_0000, 99, 3, 5};
        cnt_vals  = '{5, 2, 40, 0, 1, 12, 37, 7, 3};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // define every coordinate a tour can reach first so it never reads an unwritten city
        push_load(0, 0, 0);
        push_load(1, 65535, 65535);
        for (int unsigned i = 2; i < NLOAD; i++)
            push_load(i, $urandom(), $urandom());
        drain();

        // directed: tie-breaking, extremes, odd commands
        write_reg(CFG_COUNT, 5);
        push_cmd(CMD_STEP);
        push_cmd(CMD_NOP);
        push_load(1, 100, 0);
        push_load(2, 0, 100);
        push_load(3, 100, 0);
        push_load(4, 0, 0);
        for (int i = 0; i < 2; i++) begin
            push_cmd(CMD_START);
            repeat (3) push_cmd(CMD_STEP);
            push_load(1, 65535, 0);
            repeat (3) push_cmd(CMD_STEP);
        end
        push_load(1023, 65535, 65535);
        push_load(1, 65535, 65535);
        drain();

        for (int p = 0; p < 9; p++) begin
            write_reg(CFG_THRESHOLD, thr_vals[p]);
            write_reg(CFG_SEED, seed_vals[p]);
            write_reg(CFG_COUNT, cnt_vals[p]);
            idle_mode = p % 4;
            eff = (cnt_vals[p][10:0] > NCITY) ? NCITY : cnt_vals[p][10:0];
            if (p == 5) begin
                hold_go = 1;
                for (int k = 0; k < 40; k++)
                    push_load($urandom_range(NCITY - 1), $urandom(), $urandom());
            end
            run_phase((eff > 16) ? 20 : 54, eff);
            drain();
        end

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS randomized_nearest_neighbor_tour");
        else
            $display("FAIL randomized_nearest_neighbor_tour");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL randomized_nearest_neighbor_tour");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rnnt_pkg.sv
hw/rtl/rnnt_isqrt.sv
hw/rtl/randomized_nearest_neighbor_tour.sv
dv/tb_top.sv
